[rtl/core/rfbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rfbs_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CountW   = 3;
    localparam int unsigned ColorW   = 24;
    localparam int unsigned NumColor = 4;
    localparam int unsigned FrameW   = ColorW * NumColor;
    localparam int unsigned InDataW  = ((CountW + FrameW + 7) / 8) * 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned SelW     = 2;
    localparam int unsigned RemainW  = 4;

    localparam logic [CfgIdxW-1:0] REG_START_ONE   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_START_TWO   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_START_THREE = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_START_FOUR  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_END_FLAG    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ESCAPE      = 3'd5;

    localparam logic [ByteW-1:0] RST_START_ONE   = 8'd241;
    localparam logic [ByteW-1:0] RST_START_TWO   = 8'd242;
    localparam logic [ByteW-1:0] RST_START_THREE = 8'd243;
    localparam logic [ByteW-1:0] RST_START_FOUR  = 8'd244;
    localparam logic [ByteW-1:0] RST_END_FLAG    = 8'd51;
    localparam logic [ByteW-1:0] RST_ESCAPE      = 8'd153;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_DATA  = 4'b0100,
        ST_END   = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_start;
        logic emit_escape;
        logic emit_data;
        logic emit_end;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic is_special;
        logic data_last;
    } t_stat;

endpackage
`default_nettype wire

[rtl/core/rfbs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module rfbs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rfbs_pkg::t_stat i_stat,
    output rfbs_pkg::t_cmd     o_cmd
);

    rfbs_pkg::t_state r_state;
    rfbs_pkg::t_state n_state;
    logic             r_esc_sent;
    logic             n_esc_sent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rfbs_pkg::ST_IDLE;
            r_esc_sent <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_esc_sent <= n_esc_sent;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_esc_sent = r_esc_sent;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rfbs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rfbs_pkg::ST_START;
                end
            end
            rfbs_pkg::ST_START: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_start = 1'b1;
                    n_esc_sent       = 1'b0;
                    n_state          = rfbs_pkg::ST_DATA;
                end
            end
            rfbs_pkg::ST_DATA: begin
                if (i_stat.out_free) begin
                    if (i_stat.is_special && !r_esc_sent) begin
                        o_cmd.emit_escape = 1'b1;
                        n_esc_sent        = 1'b1;
                    end else begin
                        o_cmd.emit_data = 1'b1;
                        n_esc_sent      = 1'b0;
                        if (i_stat.data_last) begin
                            n_state = rfbs_pkg::ST_END;
                        end
                    end
                end
            end
            rfbs_pkg::ST_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = rfbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rfbs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/rfbs_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module rfbs_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [rfbs_pkg::InDataW-1:0]       i_in_data,
    input  wire logic                               i_cfg_wr,
    input  wire logic [rfbs_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  wire logic [rfbs_pkg::ByteW-1:0]         i_cfg_data,
    input  wire rfbs_pkg::t_cmd                     i_cmd,
    output rfbs_pkg::t_stat                         o_stat,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [rfbs_pkg::ByteW-1:0]              o_out_data,
    output logic                                    o_out_last
);

    logic [rfbs_pkg::ByteW-1:0]   r_start_flag [rfbs_pkg::NumColor];
    logic [rfbs_pkg::ByteW-1:0]   r_end_flag;
    logic [rfbs_pkg::ByteW-1:0]   r_escape;

    logic [rfbs_pkg::FrameW-1:0]  r_colors;
    logic [rfbs_pkg::SelW-1:0]    r_sel;
    logic [rfbs_pkg::RemainW-1:0] r_remain;
    logic [rfbs_pkg::SelW-1:0]    n_sel;
    logic [rfbs_pkg::RemainW-1:0] n_remain;
    logic [rfbs_pkg::CountW-1:0]  w_count;

    logic                         r_out_valid;
    logic [rfbs_pkg::ByteW-1:0]   r_out_data;
    logic                         r_out_last;
    logic [rfbs_pkg::ByteW-1:0]   n_out_data;
    logic                         w_emit;
    logic [rfbs_pkg::ByteW-1:0]   w_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_flag[0] <= rfbs_pkg::RST_START_ONE;
            r_start_flag[1] <= rfbs_pkg::RST_START_TWO;
            r_start_flag[2] <= rfbs_pkg::RST_START_THREE;
            r_start_flag[3] <= rfbs_pkg::RST_START_FOUR;
            r_end_flag      <= rfbs_pkg::RST_END_FLAG;
            r_escape        <= rfbs_pkg::RST_ESCAPE;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                rfbs_pkg::REG_START_ONE:   r_start_flag[0] <= i_cfg_data;
                rfbs_pkg::REG_START_TWO:   r_start_flag[1] <= i_cfg_data;
                rfbs_pkg::REG_START_THREE: r_start_flag[2] <= i_cfg_data;
                rfbs_pkg::REG_START_FOUR:  r_start_flag[3] <= i_cfg_data;
                rfbs_pkg::REG_END_FLAG:    r_end_flag      <= i_cfg_data;
                rfbs_pkg::REG_ESCAPE:      r_escape        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_count = i_in_data[rfbs_pkg::CountW-1:0];

    // saturate count to one..four
    always_comb begin
        case (w_count)
            3'd0, 3'd1: n_sel = 2'd0;
            3'd2:       n_sel = 2'd1;
            3'd3:       n_sel = 2'd2;
            default:    n_sel = 2'd3;
        endcase
        case (n_sel)
            2'd0:    n_remain = 4'd2;
            2'd1:    n_remain = 4'd5;
            2'd2:    n_remain = 4'd8;
            default: n_remain = 4'd11;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_colors <= i_in_data[rfbs_pkg::CountW +: rfbs_pkg::FrameW];
            r_sel    <= n_sel;
            r_remain <= n_remain;
        end else if (i_cmd.emit_data) begin
            r_colors <= {{rfbs_pkg::ByteW{1'b0}},
                         r_colors[rfbs_pkg::FrameW-1:rfbs_pkg::ByteW]};
            r_remain <= r_remain - 4'd1;
        end
    end

    assign w_cur = r_colors[rfbs_pkg::ByteW-1:0];

    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.data_last  = (r_remain == '0);
    assign o_stat.is_special = (w_cur == r_start_flag[0]) || (w_cur == r_start_flag[1])
                            || (w_cur == r_start_flag[2]) || (w_cur == r_start_flag[3])
                            || (w_cur == r_end_flag)      || (w_cur == r_escape);

    assign w_emit = i_cmd.emit_start || i_cmd.emit_escape || i_cmd.emit_data
                 || i_cmd.emit_end;

    always_comb begin
        n_out_data = w_cur;
        if (i_cmd.emit_start) begin
            n_out_data = r_start_flag[r_sel];
        end else if (i_cmd.emit_escape) begin
            n_out_data = r_escape;
        end else if (i_cmd.emit_end) begin
            n_out_data = r_end_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= n_out_data;
            r_out_last <= i_cmd.emit_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

[rtl/core/rgb_frame_byte_stuffer.sv]
// Byte-stuffing framer for frames of one to four 24-bit colors.
// Slave stream: one word per frame request; tdata bits 2:0 channel count,
// then color zero to color three, 24 bits each, red in the low byte.
// Master stream: one framed byte per word in tdata; tlast marks the end flag.
// Config channel: write register index and byte; indexes above five are
// ignored. Write only while no frame is in flight.
// Each frame emits start flag, the color bytes with an escape byte before any
// byte equal to one of the six codes, then the end flag: 5 to 26 bytes.
// After a request is accepted, the START state loads the start flag into the
// output register. Throughput: one output byte per cycle while the master
// side is ready, set by the single output register; a new request is taken
// only in the idle state, after the end flag is registered. The end flag may
// still wait in the output register while the next request is accepted.
// Reset restores the default codes and empties the output register.
// A master stall holds the current byte and stops the sequencer outside idle.
`timescale 1ns / 1ps
`default_nettype none
module rgb_frame_byte_stuffer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // channel_count, color_zero, color_one, color_two, color_three, zero pad
    input  wire logic [rfbs_pkg::InDataW-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // byte_out
    output logic [rfbs_pkg::ByteW-1:0]             m_axis_tdata,
    output logic                                   m_axis_tlast,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rfbs_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  wire logic [rfbs_pkg::ByteW-1:0]        i_cfg_data
);

    rfbs_pkg::t_cmd  w_cmd;
    rfbs_pkg::t_stat w_stat;
    logic            w_in_ready;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_in_ready;

    rfbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rfbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire
